>>> sv/frustum_cull_test_macros.svh
// Assertion macros used by the checker file of the frustum cull test block
`ifndef FRUSTUM_CULL_TEST_MACROS_SVH
`define FRUSTUM_CULL_TEST_MACROS_SVH

// Check a property on every clock edge outside reset
`define FCT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("frustum cull check failed in %m");

// Check a property on every clock edge, reset included
`define FCT_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("frustum cull check failed in %m");

`endif

>>> sv/fct_pkg.sv
// Shared types and constants of the frustum cull test block
package fct_pkg;

  localparam int NUM_PLANES     = 6;
  localparam int CFG_ADDR_BITS  = 6;
  localparam int REG_ADDR_LSB   = 3;
  localparam int PLANE_IDX_BITS = CFG_ADDR_BITS - REG_ADDR_LSB;
  localparam int CFG_DATA_BITS  = 64;
  localparam int FIELD_BITS     = 16;
  // Q11.4 offset and radius brought to the 18 fraction bits of a distance
  localparam int OFF_SHIFT      = 14;

  typedef enum logic [1:0] {
    OP_BOX    = 2'd0,
    OP_SPHERE = 2'd1,
    OP_POINT  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    V_REJECT    = 2'd0,
    V_INTERSECT = 2'd1,
    V_INSIDE    = 2'd2
  } verdict_e;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] off;
    logic signed [FIELD_BITS-1:0] nz;
    logic signed [FIELD_BITS-1:0] ny;
    logic signed [FIELD_BITS-1:0] nx;
  } plane_t;

  // Per-plane outcome of one word, handed to the final vote
  typedef struct packed {
    logic                  none;
    logic [NUM_PLANES-1:0] rej;
    logic [NUM_PLANES-1:0] beh;
  } flags_t;

endpackage

>>> sv/fct_cfg.sv
// Plane register file behind the APB-style configuration port
module fct_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [fct_pkg::CFG_ADDR_BITS-1:0]   paddr_i,
  input  logic [fct_pkg::CFG_DATA_BITS-1:0]   pwdata_i,
  output logic [fct_pkg::CFG_DATA_BITS-1:0]   prdata_o,
  output logic                                pready_o,
  output fct_pkg::plane_t                     planes_o [fct_pkg::NUM_PLANES]
);
  import fct_pkg::*;

  plane_t                    planes_q [NUM_PLANES];
  logic [PLANE_IDX_BITS-1:0] idx;
  logic                      wr_en;

  assign pready_o = 1'b1;
  assign idx      = paddr_i[CFG_ADDR_BITS-1:REG_ADDR_LSB];
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) planes_q[p] <= '0;
    end else if (wr_en) begin
      // addresses past the last plane are dropped
      for (int p = 0; p < NUM_PLANES; p++) begin
        if (idx == PLANE_IDX_BITS'(p)) planes_q[p] <= plane_t'(pwdata_i);
      end
    end
  end

  always_comb begin
    prdata_o = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (idx == PLANE_IDX_BITS'(p)) prdata_o = CFG_DATA_BITS'(planes_q[p]);
    end
  end

  assign planes_o = planes_q;

endmodule

>>> sv/fct_mul.sv
// First pipeline stage: vertex selection and normal-by-coordinate products
module fct_mul #(
  parameter  int COORD_BITS = 16,
  localparam int PW         = fct_pkg::FIELD_BITS + COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  fct_pkg::op_e                 op_i,
  input  logic signed [COORD_BITS-1:0] lo_i [3],
  input  logic signed [COORD_BITS-1:0] hi_i [3],
  input  logic [COORD_BITS-2:0]        radius_i,
  input  fct_pkg::plane_t              planes_i [fct_pkg::NUM_PLANES],
  output logic                         valid_o,
  input  logic                         ready_i,
  output fct_pkg::op_e                 op_o,
  output logic [COORD_BITS-2:0]        radius_o,
  output logic signed [PW-1:0]         prod_a_o [fct_pkg::NUM_PLANES][3],
  output logic signed [PW-1:0]         prod_b_o [fct_pkg::NUM_PLANES][3]
);
  import fct_pkg::*;

  logic signed [FIELD_BITS-1:0] nrm   [NUM_PLANES][3];
  logic signed [COORD_BITS-1:0] vtx_a [NUM_PLANES][3];
  logic signed [COORD_BITS-1:0] vtx_b [NUM_PLANES][3];
  logic signed [PW-1:0]         prod_a_d [NUM_PLANES][3];
  logic signed [PW-1:0]         prod_b_d [NUM_PLANES][3];
  logic signed [PW-1:0]         prod_a_q [NUM_PLANES][3];
  logic signed [PW-1:0]         prod_b_q [NUM_PLANES][3];
  op_e                          op_q;
  logic [COORD_BITS-2:0]        radius_q;
  logic                         valid_q;
  logic                         load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      nrm[p][0] = planes_i[p].nx;
      nrm[p][1] = planes_i[p].ny;
      nrm[p][2] = planes_i[p].nz;
      for (int a = 0; a < 3; a++) begin
        // box: vertex a lies furthest along the normal, vertex b furthest against it
        if (op_i == OP_BOX && !nrm[p][a][FIELD_BITS-1]) begin
          vtx_a[p][a] = hi_i[a];
          vtx_b[p][a] = lo_i[a];
        end else if (op_i == OP_BOX) begin
          vtx_a[p][a] = lo_i[a];
          vtx_b[p][a] = hi_i[a];
        end else begin
          vtx_a[p][a] = lo_i[a];
          vtx_b[p][a] = lo_i[a];
        end
        prod_a_d[p][a] = PW'(nrm[p][a]) * PW'(vtx_a[p][a]);
        prod_b_d[p][a] = PW'(nrm[p][a]) * PW'(vtx_b[p][a]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q     <= op_i;
      radius_q <= radius_i;
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
    end
  end

  assign valid_o  = valid_q;
  assign op_o     = op_q;
  assign radius_o = radius_q;
  assign prod_a_o = prod_a_q;
  assign prod_b_o = prod_b_q;

endmodule

>>> sv/fct_dist.sv
// Second and third pipeline stages: plane distances and per-plane side tests
module fct_dist #(
  parameter  int COORD_BITS = 16,
  localparam int PW         = fct_pkg::FIELD_BITS + COORD_BITS,
  localparam int DW         = ((PW > 30) ? PW : 30) + 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  fct_pkg::op_e          op_i,
  input  logic [COORD_BITS-2:0] radius_i,
  input  logic signed [PW-1:0]  prod_a_i [fct_pkg::NUM_PLANES][3],
  input  logic signed [PW-1:0]  prod_b_i [fct_pkg::NUM_PLANES][3],
  input  fct_pkg::plane_t       planes_i [fct_pkg::NUM_PLANES],
  output logic                  valid_o,
  input  logic                  ready_i,
  output fct_pkg::flags_t       flags_o
);
  import fct_pkg::*;

  // stage two: sum of the three products
  logic signed [DW-1:0]  sum_a_d [NUM_PLANES];
  logic signed [DW-1:0]  sum_b_d [NUM_PLANES];
  logic signed [DW-1:0]  sum_a_q [NUM_PLANES];
  logic signed [DW-1:0]  sum_b_q [NUM_PLANES];
  op_e                   op2_q;
  logic [COORD_BITS-2:0] rad2_q;
  logic                  v2_q;
  logic                  rdy2;
  // stage three: offset and radius added, sign taken
  logic [DW-1:0]         off_ext [NUM_PLANES];
  logic [DW-1:0]         rad_ext;
  logic [DW-1:0]         dist_a  [NUM_PLANES];
  logic [DW-1:0]         dist_b  [NUM_PLANES];
  flags_t                flags_d;
  flags_t                flags_q;
  logic                  v3_q;
  logic                  rdy3;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign ready_o = rdy2;

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      sum_a_d[p] = DW'(prod_a_i[p][0]) + DW'(prod_a_i[p][1]) + DW'(prod_a_i[p][2]);
      sum_b_d[p] = DW'(prod_b_i[p][0]) + DW'(prod_b_i[p][1]) + DW'(prod_b_i[p][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy2) begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      op2_q   <= op_i;
      rad2_q  <= radius_i;
    end
  end

  // vertex b of a sphere carries the radius, so one sign test covers it
  assign rad_ext = (op2_q == OP_SPHERE) ? (DW'({1'b0, rad2_q}) << OFF_SHIFT) : '0;

  always_comb begin
    flags_d.none = (op2_q == OP_NONE);
    for (int p = 0; p < NUM_PLANES; p++) begin
      off_ext[p] = DW'(planes_i[p].off) << OFF_SHIFT;
      dist_a[p]  = sum_a_q[p] + off_ext[p];
      dist_b[p]  = sum_b_q[p] + off_ext[p] + rad_ext;
      case (op2_q)
        OP_BOX, OP_POINT: flags_d.rej[p] = dist_a[p][DW-1];
        OP_SPHERE:        flags_d.rej[p] = dist_b[p][DW-1];
        default:          flags_d.rej[p] = 1'b0;
      endcase
      flags_d.beh[p] = (op2_q == OP_BOX) && dist_b[p][DW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) flags_q <= flags_d;
  end

  assign valid_o = v3_q;
  assign flags_o = flags_q;

endmodule

>>> sv/fct_vote.sv
// Final pipeline stage: combine the plane tests into one verdict
module fct_vote (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  fct_pkg::flags_t     flags_i,
  output logic                valid_o,
  input  logic                ready_i,
  output fct_pkg::verdict_e   verdict_o
);
  import fct_pkg::*;

  verdict_e verdict_d;
  verdict_e verdict_q;
  logic     valid_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    if (flags_i.none || (|flags_i.rej)) begin
      verdict_d = V_REJECT;
    end else if (|flags_i.beh) begin
      verdict_d = V_INTERSECT;
    end else begin
      verdict_d = V_INSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) verdict_q <= verdict_d;
  end

  assign valid_o   = valid_q;
  assign verdict_o = verdict_q;

endmodule

>>> sv/frustum_cull_test.sv
// Top level of the frustum cull test block
// Classifies one box, sphere or point per word against six planes held in 64-bit
// registers at byte addresses 0, 8, .. 40. A word is taken every cycle while
// stall_o is low and passes the product stage (36 parallel 16 by COORD_BITS
// multipliers), the product sum, the offset add and sign test, and the final vote.
// An output stall holds every full stage and reaches stall_o combinationally
// through the stage ready chain; empty stages keep taking words. The user must
// write plane registers only while no word is in flight; the block does not check.
module frustum_cull_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fct_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [fct_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [fct_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic [1:0]                          op_i,
  input  logic signed [COORD_BITS-1:0]        pos_x_i,
  input  logic signed [COORD_BITS-1:0]        pos_y_i,
  input  logic signed [COORD_BITS-1:0]        pos_z_i,
  input  logic signed [COORD_BITS-1:0]        max_x_i,
  input  logic signed [COORD_BITS-1:0]        max_y_i,
  input  logic signed [COORD_BITS-1:0]        max_z_i,
  input  logic [COORD_BITS-2:0]               radius_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic [1:0]                          verdict_o
);
  import fct_pkg::*;

  localparam int PW = FIELD_BITS + COORD_BITS;

  plane_t                planes [NUM_PLANES];
  logic signed [COORD_BITS-1:0] lo [3];
  logic signed [COORD_BITS-1:0] hi [3];
  logic                  mul_ready;
  logic                  mul_valid;
  op_e                   mul_op;
  logic [COORD_BITS-2:0] mul_radius;
  logic signed [PW-1:0]  prod_a [NUM_PLANES][3];
  logic signed [PW-1:0]  prod_b [NUM_PLANES][3];
  logic                  dist_ready;
  logic                  dist_valid;
  flags_t                flags;
  logic                  vote_ready;
  verdict_e              verdict;

  assign lo[0] = pos_x_i;
  assign lo[1] = pos_y_i;
  assign lo[2] = pos_z_i;
  assign hi[0] = max_x_i;
  assign hi[1] = max_y_i;
  assign hi[2] = max_z_i;

  fct_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .planes_o  (planes)
  );

  fct_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .ready_o  (mul_ready),
    .op_i     (op_e'(op_i)),
    .lo_i     (lo),
    .hi_i     (hi),
    .radius_i (radius_i),
    .planes_i (planes),
    .valid_o  (mul_valid),
    .ready_i  (dist_ready),
    .op_o     (mul_op),
    .radius_o (mul_radius),
    .prod_a_o (prod_a),
    .prod_b_o (prod_b)
  );

  fct_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mul_valid),
    .ready_o  (dist_ready),
    .op_i     (mul_op),
    .radius_i (mul_radius),
    .prod_a_i (prod_a),
    .prod_b_i (prod_b),
    .planes_i (planes),
    .valid_o  (dist_valid),
    .ready_i  (vote_ready),
    .flags_o  (flags)
  );

  fct_vote u_vote (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (dist_valid),
    .ready_o   (vote_ready),
    .flags_i   (flags),
    .valid_o   (valid_o),
    .ready_i   (!stall_i),
    .verdict_o (verdict)
  );

  assign stall_o   = !mul_ready;
  assign verdict_o = 2'(verdict);

endmodule

>>> sv/fct_chk.sv
// Port-level checks of the frustum cull test block and their binding
`include "frustum_cull_test_macros.svh"

module fct_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [fct_pkg::CFG_ADDR_BITS-1:0] paddr,
  input logic [fct_pkg::CFG_DATA_BITS-1:0] pwdata,
  input logic [fct_pkg::CFG_DATA_BITS-1:0] prdata,
  input logic                              pready,
  input logic                              valid_o,
  input logic                              stall_i,
  input logic [1:0]                        verdict_o
);
  import fct_pkg::*;

  logic                      cfg_wr;
  logic [PLANE_IDX_BITS-1:0] cfg_idx;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_ADDR_BITS-1:REG_ADDR_LSB];

  // reset seen at an edge leaves no word at the output on the next one
  `FCT_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !valid_o)
  // a stalled verdict is held
  `FCT_ASSERT(a_stall_hold, valid_o && stall_i |=> valid_o && $stable(verdict_o))
  // only reject, intersect and inside are ever produced
  `FCT_ASSERT(a_verdict_code, valid_o |-> verdict_o != 2'd3)
  // a plane write reads back at the same address
  `FCT_ASSERT(a_cfg_readback,
    cfg_wr && (cfg_idx < PLANE_IDX_BITS'(NUM_PLANES)) |=>
      (paddr != $past(paddr)) || (prdata == $past(pwdata)))

endmodule

bind frustum_cull_test fct_chk u_chk (.*);
